[design/rnms_pkg.sv]
// rnms_pkg: types and constants shared by the radius non-max suppression block
// depends on nothing; used by rnms_dist and radius_non_max_suppression_unit
package rnms_pkg;

  localparam int TABLE_DEPTH  = 64;
  localparam int ADDR_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
  localparam int COORD_W      = 16;
  localparam int SCORE_W      = 16;
  localparam int SQ_W         = 2 * COORD_W;
  localparam int RADIUS_W     = 34;
  localparam int ENTRY_W      = 3 * COORD_W + SCORE_W;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(10000);

  // one table entry, x in the lowest bits
  typedef struct packed {
    logic [SCORE_W-1:0]        score;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } entry_t;

  // control of the shared square-accumulate unit
  typedef struct packed {
    logic en;
    logic clear;
  } dist_ctl_t;

endpackage

[design/rnms_ram.sv]
// rnms_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
module rnms_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/rnms_dist.sv]
// rnms_dist: shared square-accumulate unit, one axis per cycle while ctl.en is high
// depends on rnms_pkg
module rnms_dist (
  input  logic                               clk,
  input  rnms_pkg::dist_ctl_t                ctl,
  input  logic signed [rnms_pkg::COORD_W-1:0] a,
  input  logic signed [rnms_pkg::COORD_W-1:0] b,
  output logic [rnms_pkg::RADIUS_W-1:0]      acc
);

  logic signed [rnms_pkg::COORD_W:0]   diff;
  logic [rnms_pkg::COORD_W-1:0]        mag;
  logic [rnms_pkg::SQ_W-1:0]           sq;
  logic [rnms_pkg::RADIUS_W-1:0]       acc_r;
  logic [rnms_pkg::RADIUS_W-1:0]       acc_nxt;

  always_comb begin
    diff = {a[rnms_pkg::COORD_W-1], a} - {b[rnms_pkg::COORD_W-1], b};
    // magnitude of a 17-bit difference always fits in 16 bits
    mag  = diff[rnms_pkg::COORD_W] ? rnms_pkg::COORD_W'(-diff)
                                   : diff[rnms_pkg::COORD_W-1:0];
    sq   = mag * mag;
    acc_nxt = ctl.clear ? rnms_pkg::RADIUS_W'(sq)
                        : acc_r + rnms_pkg::RADIUS_W'(sq);
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

[design/radius_non_max_suppression_unit.sv]
// radius_non_max_suppression_unit: top level, scan sequencer, survivor table and output stage
// depends on rnms_pkg, rnms_ram, rnms_dist
//
// channel | direction | tdata (low bit up)              | tlast      | tuser
// in_     | slave     | pos_x, pos_y, pos_z, score      | last_point | -
// out_    | master    | out_x, out_y, out_z, out_score  | out_last   | overflow
// cfg_    | write     | radius_squared (34 bits)        | -          | -
//
// for each stored survivor compared, an item takes the one squarer through the three axes, then a
// compare; a point not suppressed is then appended, or sets overflow when the table is full
// a suppression after a removal moves the remaining survivors down to close the gap
// a last item then emits every survivor, each read and then loaded once the output register frees
// reset clears the survivor count and overflow flag and sets the radius to 10000; table contents stay unknown
// in_tready is high only between items; a held final output item does not block the next input
module radius_non_max_suppression_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [63:0]                    in_tdata,    // pos_x, pos_y, pos_z, score
  input  logic                           in_tlast,    // last_point
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [63:0]                    out_tdata,   // out_x, out_y, out_z, out_score
  output logic                           out_tlast,   // out_last
  output logic [0:0]                     out_tuser,   // overflow
  input  logic                           cfg_wr_en,
  input  logic [rnms_pkg::RADIUS_W-1:0]  cfg_wr_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_SX, S_SY, S_SZ, S_DEC, S_CP, S_APP, S_EMRD, S_EMLD
  } state_t;

  state_t                           state_r, state_nxt;
  logic [rnms_pkg::CNT_W-1:0]       r_r, r_nxt;
  logic [rnms_pkg::CNT_W-1:0]       w_r, w_nxt;
  logic [rnms_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [rnms_pkg::CNT_W-1:0]       e_r, e_nxt;
  logic                             ovf_r, ovf_nxt;
  logic                             last_r, last_nxt;
  rnms_pkg::entry_t                 p_r, p_nxt;
  rnms_pkg::entry_t                 ent_r, ent_nxt;
  rnms_pkg::entry_t                 out_data_r, out_data_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_last_r, out_last_nxt;
  logic                             out_ovf_r, out_ovf_nxt;
  logic [rnms_pkg::RADIUS_W-1:0]    radius_r;

  logic                             mem_wr_en;
  logic [rnms_pkg::ADDR_W-1:0]      mem_wr_addr;
  rnms_pkg::entry_t                 mem_wr_data;
  logic                             mem_rd_en;
  logic [rnms_pkg::ADDR_W-1:0]      mem_rd_addr;
  logic [rnms_pkg::ENTRY_W-1:0]     mem_rd_raw;
  rnms_pkg::entry_t                 rd_ent;

  rnms_pkg::dist_ctl_t              dctl;
  logic signed [rnms_pkg::COORD_W-1:0] da, db;
  logic [rnms_pkg::RADIUS_W-1:0]    acc;

  logic [rnms_pkg::CNT_W-1:0]       r1;
  logic                             near;
  logic                             stronger;
  logic                             em_load;

  rnms_ram #(
    .WIDTH(rnms_pkg::ENTRY_W),
    .DEPTH(rnms_pkg::TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_raw)
  );

  rnms_dist u_dist (
    .clk(clk),
    .ctl(dctl),
    .a  (da),
    .b  (db),
    .acc(acc)
  );

  assign rd_ent = rnms_pkg::entry_t'(mem_rd_raw);

  always_comb begin
    state_nxt     = state_r;
    r_nxt         = r_r;
    w_nxt         = w_r;
    cnt_nxt       = cnt_r;
    e_nxt         = e_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    p_nxt         = p_r;
    ent_nxt       = ent_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    r1            = r_r + rnms_pkg::CNT_W'(1);
    mem_wr_en     = 1'b0;
    mem_wr_addr   = w_r[rnms_pkg::ADDR_W-1:0];
    mem_wr_data   = ent_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = r1[rnms_pkg::ADDR_W-1:0];
    dctl          = '0;
    da            = p_r.x;
    db            = ent_r.x;
    near          = acc < radius_r;
    stronger      = p_r.score > ent_r.score;
    em_load       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          p_nxt    = rnms_pkg::entry_t'(in_tdata);
          last_nxt = in_tlast;
          r_nxt    = '0;
          w_nxt    = '0;
          if (cnt_r == '0) begin
            state_nxt = S_APP;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
            state_nxt   = S_SX;
          end
        end
      end
      S_SX: begin
        dctl.en    = 1'b1;
        dctl.clear = 1'b1;
        db         = rd_ent.x;
        ent_nxt    = rd_ent;
        state_nxt  = S_SY;
      end
      S_SY: begin
        dctl.en   = 1'b1;
        da        = p_r.y;
        db        = ent_r.y;
        state_nxt = S_SZ;
      end
      S_SZ: begin
        dctl.en   = 1'b1;
        da        = p_r.z;
        db        = ent_r.z;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        priority if (near && stronger) begin
          // entry dropped: not written back, write index holds
          r_nxt = r1;
          if (r1 < cnt_r) begin
            mem_rd_en = 1'b1;
            state_nxt = S_SX;
          end else begin
            state_nxt = S_APP;
          end
        end else if (near) begin
          // new point suppressed; close the gap left by earlier removals
          if (w_r == r_r) begin
            e_nxt     = '0;
            state_nxt = last_r ? S_EMRD : S_IDLE;
          end else begin
            mem_wr_en = 1'b1;
            w_nxt     = w_r + rnms_pkg::CNT_W'(1);
            r_nxt     = r1;
            if (r1 < cnt_r) begin
              mem_rd_en = 1'b1;
              state_nxt = S_CP;
            end else begin
              cnt_nxt   = w_r + rnms_pkg::CNT_W'(1);
              e_nxt     = '0;
              state_nxt = last_r ? S_EMRD : S_IDLE;
            end
          end
        end else begin
          mem_wr_en = 1'b1;
          w_nxt     = w_r + rnms_pkg::CNT_W'(1);
          r_nxt     = r1;
          if (r1 < cnt_r) begin
            mem_rd_en = 1'b1;
            state_nxt = S_SX;
          end else begin
            state_nxt = S_APP;
          end
        end
      end
      S_CP: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = rd_ent;
        w_nxt       = w_r + rnms_pkg::CNT_W'(1);
        r_nxt       = r1;
        if (r1 < cnt_r) begin
          mem_rd_en = 1'b1;
        end else begin
          cnt_nxt   = w_r + rnms_pkg::CNT_W'(1);
          e_nxt     = '0;
          state_nxt = last_r ? S_EMRD : S_IDLE;
        end
      end
      S_APP: begin
        if (w_r < rnms_pkg::CNT_W'(rnms_pkg::TABLE_DEPTH)) begin
          mem_wr_en   = 1'b1;
          mem_wr_data = p_r;
          cnt_nxt     = w_r + rnms_pkg::CNT_W'(1);
        end else begin
          cnt_nxt = w_r;
          ovf_nxt = 1'b1;
        end
        e_nxt     = '0;
        state_nxt = last_r ? S_EMRD : S_IDLE;
      end
      S_EMRD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = e_r[rnms_pkg::ADDR_W-1:0];
        state_nxt   = S_EMLD;
      end
      S_EMLD: begin
        // read data holds until the output register frees up
        if (!out_valid_r || out_tready) begin
          em_load       = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = rd_ent;
          out_last_nxt  = (e_r + rnms_pkg::CNT_W'(1)) == cnt_r;
          out_ovf_nxt   = ovf_r;
          e_nxt         = e_r + rnms_pkg::CNT_W'(1);
          if ((e_r + rnms_pkg::CNT_W'(1)) == cnt_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_EMRD;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      r_r         <= '0;
      w_r         <= '0;
      cnt_r       <= '0;
      e_r         <= '0;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      radius_r    <= rnms_pkg::RADIUS_RESET;
    end else begin
      state_r     <= state_nxt;
      r_r         <= r_nxt;
      w_r         <= w_nxt;
      cnt_r       <= cnt_nxt;
      e_r         <= e_nxt;
      ovf_r       <= ovf_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        radius_r <= cfg_wr_data;
      end
    end
    p_r        <= p_nxt;
    ent_r      <= ent_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  // compaction never writes ahead of the entry being read
  a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEC || state_r == S_CP) |-> (w_r <= r_r))
    else $error("write index passed read index");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rnms_pkg::CNT_W'(rnms_pkg::TABLE_DEPTH))
    else $error("survivor count above table depth");

  // the final emitted survivor starts a fresh set
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (em_load && out_last_nxt) |=> (cnt_r == '0 && !ovf_r && state_r == S_IDLE))
    else $error("set not cleared after emission");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_EMRD || state_r == S_EMLD) |-> !mem_wr_en)
    else $error("table written outside scan");

endmodule
